// ----- src/scanline_run_length_decoder_core_assert.svh -----
// Assertion macros for the scanline run-length decoder.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef SCANLINE_RUN_LENGTH_DECODER_CORE_ASSERT_SVH
`define SCANLINE_RUN_LENGTH_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SRLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SRLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/srld_pkg.sv -----
// Package for the scanline run-length decoder: phase type, queue entry type
// and shared constants. No dependencies.
package srld_pkg;

	localparam int unsigned WIDTH_W = 15;
	localparam int unsigned BYTE_W = 8;
	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 15'd1;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [BYTE_W-1:0] HDR_LIT_MIN = 8'h80;

	// Decoder phase: what the next byte means
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_RUN     = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	// One classified byte handed from the front to the back
	typedef struct packed {
		logic [BYTE_W-1:0] value;  // byte to write (0 for headers)
		logic [BYTE_W-1:0] count;  // copies wanted (0 for headers)
		logic              last;   // byte closes its packet
	} op_t;

endpackage

// ----- src/srld_if.sv -----
// Stream interfaces for the scanline run-length decoder: encoded byte in,
// decoded pixel run out. Depends on nothing.
interface code_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface pixel_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic [7:0] copies;
	logic       line_end;

	modport source (output valid, output pixel_value, output copies, output line_end,
		input ready);
	modport sink (input valid, input pixel_value, input copies, input line_end,
		output ready);
endinterface

// ----- src/scanline_run_length_decoder_core.sv -----
// Top level of the scanline run-length decoder: width register, front, queue
// and back. Depends on srld_pkg, srld_if and the assertion header.
//
// Decodes signed-byte run-length packets, one code byte per clock while the
// queue has room. Each accepted byte gives exactly one result: headers give
// value 0 and copies 0, run and literal bytes give the byte and its copy
// count clipped to the pixels left in the line, with line_end on the last
// byte of the packet that fills the line. Sustained rate is one byte per
// cycle while the output is not stalled. A byte taken goes into the
// front-to-back queue, then into the output register, from which its result
// transfers. Writing line_width flushes the decoder and starts a new line;
// write it only while the decoder is idle. No clearing pass after reset.
`include "scanline_run_length_decoder_core_assert.svh"

module scanline_run_length_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = srld_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [srld_pkg::WIDTH_W-1:0] cfg_wdata,
	code_stream_if.sink                  code_in,
	pixel_stream_if.source               pix_out
);

	logic [srld_pkg::WIDTH_W-1:0] line_width_q;
	logic [srld_pkg::WIDTH_W-1:0] width_load;
	logic          f_valid, f_ready;
	srld_pkg::op_t f_op;
	logic          b_valid, b_ready;
	srld_pkg::op_t b_op;

	// Line width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= srld_pkg::LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	// Width seen by the back: the new value in the write cycle, else the register
	assign width_load = cfg_we ? cfg_wdata : line_width_q;

	srld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (cfg_we),
		.code_in  (code_in),
		.op_valid (f_valid),
		.op       (f_op),
		.op_ready (f_ready)
	);

	srld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (cfg_we),
		.wr_valid (f_valid),
		.wr_op    (f_op),
		.wr_ready (f_ready),
		.rd_valid (b_valid),
		.rd_op    (b_op),
		.rd_ready (b_ready)
	);

	srld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.flush      (cfg_we),
		.line_width (width_load),
		.op_valid   (b_valid),
		.op         (b_op),
		.op_ready   (b_ready),
		.pix_out    (pix_out)
	);

	// Checks
	`SRLD_ASSERT_NEXT(a_cfg_flush_in, cfg_we, code_in.ready, "queue not empty after width write")
	`SRLD_ASSERT_NEXT(a_cfg_flush_out, cfg_we, !pix_out.valid, "output held after width write")
	`SRLD_ASSERT_NOW(a_copies_max, pix_out.valid, pix_out.copies <= 8'd128, "copies above packet max")

endmodule

// ----- src/srld_front.sv -----
// Front of the decoder: accepts code bytes, tracks packet phase and turns each
// byte into a queue entry. Depends on srld_pkg and code_stream_if.
module srld_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 flush,
	code_stream_if.sink          code_in,
	output logic                 op_valid,
	output srld_pkg::op_t        op,
	input  logic                 op_ready
);

	srld_pkg::phase_t phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic [7:0] pending_dec;
	logic       take;

	assign code_in.ready = op_ready;
	assign op_valid = code_in.valid;
	assign take = code_in.valid && op_ready;
	assign pending_dec = pending_q - 8'd1;

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srld_pkg::PH_HEADER;
			pending_q <= 8'd0;
		end else if (flush) begin
			phase_q <= srld_pkg::PH_HEADER;
			pending_q <= 8'd0;
		end else if (take) begin
			phase_q <= phase_d;
			pending_q <= pending_d;
		end
	end

	// Classify the byte and pick the next phase
	always_comb begin
		phase_d = phase_q;
		pending_d = pending_q;
		op.value = code_in.code_byte;
		op.count = 8'd0;
		op.last = 1'b0;
		case (phase_q)
			srld_pkg::PH_RUN: begin
				op.count = pending_q;
				op.last = 1'b1;
				pending_d = 8'd0;
				phase_d = srld_pkg::PH_HEADER;
			end
			srld_pkg::PH_LITERAL: begin
				op.count = 8'd1;
				pending_d = pending_dec;
				if (pending_dec == 8'd0) begin
					op.last = 1'b1;
					phase_d = srld_pkg::PH_HEADER;
				end
			end
			default: begin
				// header byte: emits an entry with value 0 and count 0
				op.value = 8'd0;
				if (code_in.code_byte < srld_pkg::HDR_LIT_MIN) begin
					pending_d = code_in.code_byte + 8'd1;
					phase_d = srld_pkg::PH_RUN;
				end else begin
					pending_d = (~code_in.code_byte) + 8'd1;
					phase_d = srld_pkg::PH_LITERAL;
				end
			end
		endcase
	end

endmodule

// ----- src/srld_queue.sv -----
// Short queue between decoder front and back so each side stalls on its own.
// Depends on srld_pkg.
module srld_queue #(
	parameter int unsigned DEPTH = srld_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          flush,
	input  logic          wr_valid,
	input  srld_pkg::op_t wr_op,
	output logic          wr_ready,
	output logic          rd_valid,
	output srld_pkg::op_t rd_op,
	input  logic          rd_ready
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	srld_pkg::op_t  mem_q [DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_op = mem_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else if (flush) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/srld_back.sv -----
// Back of the decoder: clips each queued entry to the pixels left in the line,
// flags line end and holds the output register. Depends on srld_pkg.
module srld_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         flush,
	input  logic [srld_pkg::WIDTH_W-1:0] line_width,
	input  logic                         op_valid,
	input  srld_pkg::op_t                op,
	output logic                         op_ready,
	pixel_stream_if.source               pix_out
);

	logic [srld_pkg::WIDTH_W-1:0] left_q, left_next;
	logic [7:0] copies;
	logic       line_end;
	logic       out_valid_q;
	logic [7:0] value_q, copies_q;
	logic       end_q;
	logic       pop;

	assign op_ready = !out_valid_q || pix_out.ready;
	assign pop = op_valid && op_ready;

	// Clip to remaining width
	always_comb begin
		if (srld_pkg::WIDTH_W'(op.count) < left_q) begin
			copies = op.count;
		end else begin
			copies = left_q[7:0];
		end
		left_next = left_q - srld_pkg::WIDTH_W'(copies);
		line_end = op.last && (left_next == '0);
	end

	// Pixels left in the current line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= srld_pkg::LINE_WIDTH_RESET;
		end else if (flush) begin
			left_q <= line_width;
		end else if (pop) begin
			left_q <= line_end ? line_width : left_next;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flush) begin
			out_valid_q <= 1'b0;
		end else if (op_ready) begin
			out_valid_q <= op_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= op.value;
			copies_q <= copies;
			end_q <= line_end;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.pixel_value = value_q;
	assign pix_out.copies = copies_q;
	assign pix_out.line_end = end_q;

endmodule
